// ===== sv/cbm_pkg.sv =====
// shared constants, codes and helper functions for the cartridge bank mapper
`default_nettype none

package cbm_pkg;

    // sizing of the cartridge stores
    localparam int MAX_ROM_BANKS = 128;
    localparam int MAX_RAM_BYTES = 32768;
    localparam int BANK_AW       = 14;
    localparam int ROM_BANK_W    = $clog2(MAX_ROM_BANKS);
    localparam int ROM_AW        = ROM_BANK_W + BANK_AW;
    localparam int RAM_AW        = $clog2(MAX_RAM_BYTES);
    localparam logic [21:0] ROM_BYTES = 22'(MAX_ROM_BANKS * (2 ** BANK_AW));

    // operation codes
    localparam logic [2:0] FN_ROM_RD   = 3'd0;
    localparam logic [2:0] FN_CTRL_WR  = 3'd1;
    localparam logic [2:0] FN_RAM_RD   = 3'd2;
    localparam logic [2:0] FN_RAM_WR   = 3'd3;
    localparam logic [2:0] FN_CLK_LOAD = 3'd4;
    localparam logic [2:0] FN_ROM_LOAD = 3'd5;

    // configuration register indexes
    localparam logic CFG_ROM_BANKS = 1'b0;
    localparam logic CFG_RAM_SIZE  = 1'b1;

    // RAM size codes
    localparam logic [1:0] RAM_NONE = 2'd0;
    localparam logic [1:0] RAM_2K   = 2'd1;
    localparam logic [1:0] RAM_8K   = 2'd2;

    // control write regions and values
    localparam logic [14:0] CTRL_BANK_LO  = 15'h2000;
    localparam logic [14:0] CTRL_SEL_LO   = 15'h4000;
    localparam logic [14:0] CTRL_LATCH_LO = 15'h6000;
    localparam logic [3:0]  RAM_EN_KEY    = 4'hA;
    localparam logic [7:0]  LATCH_ARM     = 8'h00;
    localparam logic [7:0]  LATCH_FIRE    = 8'h01;
    localparam logic [6:0]  BANK_RESET    = 7'd1;

    // RAM select range that reaches the clock bytes
    localparam logic [7:0] CLK_SEL_LO = 8'h08;
    localparam logic [7:0] CLK_SEL_HI = 8'h0C;
    localparam int         CLK_BYTES  = 5;

    localparam logic [7:0] NO_ANSWER = 8'hFF;

    // reciprocals for the clock split: x/60 is (x*RECIP_60) >> 37,
    // x/24 is (x*RECIP_24) >> 36, exact for any 32-bit x
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;

    // RAM bytes for a size code, capped at the store size
    function automatic int ram_bytes(input logic [1:0] code);
        int n;
        case (code)
            RAM_NONE: n = 0;
            RAM_2K:   n = 2048;
            RAM_8K:   n = 8192;
            default:  n = 32768;
        endcase
        if (n > MAX_RAM_BYTES) n = MAX_RAM_BYTES;
        return n;
    endfunction

    // wrap mask for a RAM index
    function automatic logic [14:0] ram_mask(input logic [1:0] code);
        int n;
        n = ram_bytes(code);
        if (n == 0) return 15'd0;
        return 15'(n - 1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/cbm_spram.sv =====
// single-port synchronous RAM with registered read data
`default_nettype none

module cbm_spram #(
    parameter int AW = 15,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/cbm_div.sv =====
// clock split of a seconds count into seconds, minutes, hours and days
`default_nettype none

module cbm_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_seconds,
    output logic             o_done,
    output logic [5:0]       o_sec,
    output logic [5:0]       o_min,
    output logic [4:0]       o_hour,
    output logic [8:0]       o_days
);

    localparam logic [1:0] STEP_SEC  = 2'd0;
    localparam logic [1:0] STEP_MIN  = 2'd1;
    localparam logic [1:0] STEP_HOUR = 2'd2;

    logic        r_busy;
    logic        r_done;
    logic        r_phase;
    logic [1:0]  r_step;
    logic [31:0] r_x;
    logic [31:0] r_q;
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hour;
    logic [8:0]  r_days;
    logic [31:0] n_recip;
    logic [63:0] n_prod;
    logic [31:0] n_q;
    logic [31:0] n_qd;
    logic [31:0] n_rem;

    // quotient by reciprocal multiply, remainder by shift and subtract
    always_comb begin
        n_recip = (r_step == STEP_HOUR) ? cbm_pkg::RECIP_24 : cbm_pkg::RECIP_60;
        n_prod  = 64'(r_x) * 64'(n_recip);
        if (r_step == STEP_HOUR) begin
            n_q  = {4'd0, n_prod[63:36]};
            n_qd = {r_q[27:0], 4'd0} + {r_q[28:0], 3'd0};
        end else begin
            n_q  = {5'd0, n_prod[63:37]};
            n_qd = {r_q[25:0], 6'd0} - {r_q[29:0], 2'd0};
        end
        n_rem = r_x - n_qd;
    end

    // control: a quotient phase and a remainder phase per step, three steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_step  <= STEP_SEC;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_step  <= STEP_SEC;
        end else begin
            r_done <= r_busy && r_phase && (r_step == STEP_HOUR);
            if (r_busy) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    if (r_step == STEP_HOUR) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
            end
        end
    end

    // datapath: quotient cycle, then remainder cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_seconds;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_q <= n_q;
            end else begin
                r_x <= r_q;
                case (r_step)
                    STEP_SEC: r_sec <= n_rem[5:0];
                    STEP_MIN: r_min <= n_rem[5:0];
                    default: begin
                        r_hour <= n_rem[4:0];
                        r_days <= r_q[8:0];
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_sec  = r_sec;
    assign o_min  = r_min;
    assign o_hour = r_hour;
    assign o_days = r_days;

endmodule

`default_nettype wire

// ===== sv/cartridge_bank_mapper_rtc_top.sv =====
// Cartridge bank controller with ROM/RAM banking and a real-time clock.
// A ROM or RAM read is accepted, the store's read register takes the byte, and the
// output register takes it once free; writes and control complete at acceptance.
// A clock load: three reciprocal divide steps, quotient then remainder, then write-back.
// After reset the RAM store is cleared one byte a cycle (all 32768 bytes, the RAM size)
// before any word is accepted; the ROM store keeps its contents across reset.
`default_nettype none

module cartridge_bank_mapper_rtc_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_func,
    input  wire logic [14:0] i_addr,
    input  wire logic [7:0]  i_value,
    input  wire logic [31:0] i_seconds,
    input  wire logic [20:0] i_load_addr,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_CLOCK = 2'd3;

    localparam logic [1:0] SRC_ROM = 2'd0;
    localparam logic [1:0] SRC_RAM = 2'd1;
    localparam logic [1:0] SRC_ALT = 2'd2;

    localparam logic [cbm_pkg::RAM_AW-1:0] CLR_LAST =
        cbm_pkg::RAM_AW'(cbm_pkg::MAX_RAM_BYTES - 1);

    logic [1:0]                r_state;
    logic [cbm_pkg::RAM_AW-1:0] r_clr_addr;
    logic [7:0]                r_rom_banks;
    logic [1:0]                r_ram_size;
    logic                      r_ram_en;
    logic [6:0]                r_bank;
    logic [7:0]                r_ram_sel;
    logic [7:0]                r_prev_latch;
    logic [7:0]                r_clk_live    [cbm_pkg::CLK_BYTES];
    logic [7:0]                r_clk_latched [cbm_pkg::CLK_BYTES];
    logic [1:0]                r_src;
    logic [7:0]                r_alt;
    logic                      r_out_valid;
    logic [7:0]                r_out_data;

    logic                      n_accept;
    logic                      n_out_free;
    logic [7:0]                n_bank_mask;
    logic [6:0]                n_rom_bank;
    logic [20:0]               n_rom_index;
    logic [14:0]               n_ram_sum;
    logic [14:0]               n_ram_index;
    logic                      n_ram_sel_mem;
    logic                      n_ram_sel_clk;
    logic                      n_ram_none;
    logic [7:0]                n_sel_off;
    logic                      n_rom_we;
    logic                      n_rom_re;
    logic [cbm_pkg::ROM_AW-1:0] n_rom_addr;
    logic                      n_ram_we;
    logic                      n_ram_re;
    logic [cbm_pkg::RAM_AW-1:0] n_ram_addr;
    logic [7:0]                n_ram_wdata;
    logic [7:0]                w_rom_q;
    logic [7:0]                w_ram_q;
    logic                      n_dv_start;
    logic                      w_dv_done;
    logic [5:0]                w_dv_sec;
    logic [5:0]                w_dv_min;
    logic [4:0]                w_dv_hour;
    logic [8:0]                w_dv_days;

    // handshake
    assign o_in_stall = (r_state != ST_IDLE);
    assign n_accept   = i_in_valid && (r_state == ST_IDLE);
    assign n_out_free = !r_out_valid || !i_out_stall;

    // ROM index: bank 0 below the switchable window
    always_comb begin
        n_bank_mask = r_rom_banks - 8'd1;
        n_rom_bank  = i_addr[14] ? (r_bank & n_bank_mask[6:0]) : 7'd0;
        n_rom_index = {n_rom_bank, i_addr[13:0]};
    end

    // RAM index wrapped to the RAM size and clock byte decode
    always_comb begin
        n_ram_sum     = {r_ram_sel[1:0], 13'd0} + i_addr;
        n_ram_index   = n_ram_sum & cbm_pkg::ram_mask(r_ram_size);
        n_ram_none    = (r_ram_size == cbm_pkg::RAM_NONE);
        n_ram_sel_mem = (r_ram_sel[7:2] == 6'd0);
        n_ram_sel_clk = (r_ram_sel >= cbm_pkg::CLK_SEL_LO) &&
                        (r_ram_sel <= cbm_pkg::CLK_SEL_HI);
        n_sel_off     = r_ram_sel - cbm_pkg::CLK_SEL_LO;
    end

    // ROM store port
    always_comb begin
        n_rom_re = n_accept && (i_func == cbm_pkg::FN_ROM_RD);
        n_rom_we = n_accept && (i_func == cbm_pkg::FN_ROM_LOAD) &&
                   ({1'b0, i_load_addr} < cbm_pkg::ROM_BYTES);
        n_rom_addr = n_rom_we ? i_load_addr[cbm_pkg::ROM_AW-1:0]
                              : n_rom_index[cbm_pkg::ROM_AW-1:0];
    end

    cbm_spram #(
        .AW (cbm_pkg::ROM_AW),
        .DW (8)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (n_rom_we),
        .i_re    (n_rom_re),
        .i_addr  (n_rom_addr),
        .i_wdata (i_value),
        .o_rdata (w_rom_q)
    );

    // RAM store port, shared with the clearing pass
    always_comb begin
        n_ram_re = n_accept && (i_func == cbm_pkg::FN_RAM_RD);
        if (r_state == ST_CLEAR) begin
            n_ram_we    = 1'b1;
            n_ram_addr  = r_clr_addr;
            n_ram_wdata = 8'd0;
        end else begin
            n_ram_we    = n_accept && (i_func == cbm_pkg::FN_RAM_WR) && r_ram_en &&
                          n_ram_sel_mem && !n_ram_none;
            n_ram_addr  = n_ram_index[cbm_pkg::RAM_AW-1:0];
            n_ram_wdata = i_value;
        end
    end

    cbm_spram #(
        .AW (cbm_pkg::RAM_AW),
        .DW (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_ram_we),
        .i_re    (n_ram_re),
        .i_addr  (n_ram_addr),
        .i_wdata (n_ram_wdata),
        .o_rdata (w_ram_q)
    );

    // clock split starts on an accepted clock load
    assign n_dv_start = n_accept && (i_func == cbm_pkg::FN_CLK_LOAD);

    cbm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (n_dv_start),
        .i_seconds (i_seconds),
        .o_done    (w_dv_done),
        .o_sec     (w_dv_sec),
        .o_min     (w_dv_min),
        .o_hour    (w_dv_hour),
        .o_days    (w_dv_days)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == CLR_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (n_accept) begin
                        case (i_func)
                            cbm_pkg::FN_ROM_RD,
                            cbm_pkg::FN_RAM_RD:   r_state <= ST_READ;
                            cbm_pkg::FN_CLK_LOAD: r_state <= ST_CLOCK;
                            default:              r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_READ: begin
                    if (n_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_CLOCK: begin
                    if (w_dv_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_banks <= 8'd2;
            r_ram_size  <= cbm_pkg::RAM_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbm_pkg::CFG_ROM_BANKS: r_rom_banks <= i_cfg_data;
                cbm_pkg::CFG_RAM_SIZE:  r_ram_size  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // control writes, clock byte writes and clock split results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_en     <= 1'b0;
            r_bank       <= cbm_pkg::BANK_RESET;
            r_ram_sel    <= 8'd0;
            r_prev_latch <= 8'd0;
            for (int k = 0; k < cbm_pkg::CLK_BYTES; k++) begin
                r_clk_live[k]    <= 8'd0;
                r_clk_latched[k] <= 8'd0;
            end
        end else begin
            if (n_accept && (i_func == cbm_pkg::FN_CTRL_WR)) begin
                if (i_addr < cbm_pkg::CTRL_BANK_LO) begin
                    r_ram_en <= (i_value[3:0] == cbm_pkg::RAM_EN_KEY);
                end else if (i_addr < cbm_pkg::CTRL_SEL_LO) begin
                    r_bank <= (i_value[6:0] == 7'd0) ? cbm_pkg::BANK_RESET : i_value[6:0];
                end else if (i_addr < cbm_pkg::CTRL_LATCH_LO) begin
                    r_ram_sel <= i_value;
                end else begin
                    if ((r_prev_latch == cbm_pkg::LATCH_ARM) &&
                        (i_value == cbm_pkg::LATCH_FIRE)) begin
                        r_clk_latched <= r_clk_live;
                    end
                    r_prev_latch <= i_value;
                end
            end
            if (n_accept && (i_func == cbm_pkg::FN_RAM_WR) && r_ram_en && n_ram_sel_clk) begin
                r_clk_live[n_sel_off[2:0]] <= i_value;
            end
            if ((r_state == ST_CLOCK) && w_dv_done) begin
                r_clk_live[0]    <= {2'd0, w_dv_sec};
                r_clk_live[1]    <= {2'd0, w_dv_min};
                r_clk_live[2]    <= {3'd0, w_dv_hour};
                r_clk_live[3]    <= w_dv_days[7:0];
                r_clk_live[4]    <= {7'd0, w_dv_days[8]};
                r_clk_latched[0] <= {2'd0, w_dv_sec};
                r_clk_latched[1] <= {2'd0, w_dv_min};
                r_clk_latched[2] <= {3'd0, w_dv_hour};
                r_clk_latched[3] <= w_dv_days[7:0];
                r_clk_latched[4] <= {7'd0, w_dv_days[8]};
            end
        end
    end

    // read source chosen at acceptance
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            if (i_func == cbm_pkg::FN_ROM_RD) begin
                r_src <= (r_rom_banks == 8'd0) ? SRC_ALT : SRC_ROM;
                r_alt <= cbm_pkg::NO_ANSWER;
            end else begin
                r_src <= (r_ram_en && n_ram_sel_mem && !n_ram_none) ? SRC_RAM : SRC_ALT;
                r_alt <= (r_ram_en && n_ram_sel_clk) ? r_clk_latched[n_sel_off[2:0]]
                                                     : cbm_pkg::NO_ANSWER;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_READ) && n_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_READ) && n_out_free) begin
            case (r_src)
                SRC_ROM: r_out_data <= w_rom_q;
                SRC_RAM: r_out_data <= w_ram_q;
                default: r_out_data <= r_alt;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

`default_nettype wire

// ===== tb/cartridge_bank_mapper_rtc_top_tb.sv =====
// self-checking testbench for the cartridge bank mapper with real-time clock
`timescale 1ns / 1ps

module cartridge_bank_mapper_rtc_top_tb;

    // codes the package leaves unnamed
    localparam logic [2:0]  FN_SPARE6     = 3'd6;
    localparam logic [2:0]  FN_SPARE7     = 3'd7;
    localparam logic [1:0]  RAM_32K       = 2'd3;
    localparam logic [7:0]  RAM_SEL_LAST  = 8'h03;
    localparam logic [14:0] ROM_SWITCH_LO = 15'h4000;

    localparam int DRAIN_CYCLES    = 150;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 9;
    localparam int WORDS_PER_PHASE = 90;

    typedef struct packed {
        logic [2:0]  func;
        logic [14:0] addr;
        logic [7:0]  value;
        logic [31:0] seconds;
        logic [20:0] load_addr;
    } t_bus_word;

    // clock and block inputs, all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data  = 8'h00;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_func      = 3'd0;
    logic [14:0] i_addr      = 15'd0;
    logic [7:0]  i_value     = 8'h00;
    logic [31:0] i_seconds   = 32'd0;
    logic [20:0] i_load_addr = 21'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_read_data;

    cartridge_bank_mapper_rtc_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_addr      (i_addr),
        .i_value     (i_value),
        .i_seconds   (i_seconds),
        .i_load_addr (i_load_addr),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_data (o_read_data)
    );

    initial forever #4 i_clk = ~i_clk;

    // mirror of the mapper state
    logic [7:0]  rom_image [logic [20:0]];
    logic [7:0]  ram_image [0:32767] = '{default: 8'h00};
    logic        ram_on           = 1'b0;
    logic [6:0]  rom_bank_reg     = cbm_pkg::BANK_RESET;
    logic [7:0]  ram_sel_reg      = 8'h00;
    logic [7:0]  last_latch_write = 8'h00;
    logic [7:0]  rtc_live    [0:4] = '{default: 8'h00};
    logic [7:0]  rtc_latched [0:4] = '{default: 8'h00};
    logic [7:0]  cfg_rom_banks = 8'd2;
    logic [1:0]  cfg_ram_code  = cbm_pkg::RAM_NONE;

    // read bytes the block still owes, oldest first
    logic [7:0]  read_bytes_due [$];
    logic [14:0] recent_rom_addr [$];
    logic [14:0] recent_ram_addr [$];

    int  errors         = 0;
    int  words_sent     = 0;
    int  reads_checked  = 0;
    int  clock_loads    = 0;
    int  settings_tried = 0;
    int  cycles         = 0;
    bit  quiet          = 1'b0;
    bit  calm           = 1'b0;

    // RAM bytes behind a size code
    function automatic int unsigned ram_span(input logic [1:0] code);
        case (code)
            cbm_pkg::RAM_NONE: return 0;
            cbm_pkg::RAM_2K:   return 2048;
            cbm_pkg::RAM_8K:   return 8192;
            default:           return 32768;
        endcase
    endfunction

    // ROM store position reached by a read address under the current bank
    function automatic logic [20:0] rom_index(input logic [14:0] addr);
        logic [7:0] bank;
        bank = 8'h00;
        if (addr >= ROM_SWITCH_LO) bank = {1'b0, rom_bank_reg} & (cfg_rom_banks - 8'd1);
        return {bank[6:0], addr[13:0]};
    endfunction

    function automatic int unsigned ram_spot(input logic [14:0] addr);
        return (32'(ram_sel_reg) * 32'h2000 + 32'(addr)) % ram_span(cfg_ram_code);
    endfunction

    function automatic bit clock_selected();
        return ram_sel_reg >= cbm_pkg::CLK_SEL_LO && ram_sel_reg <= cbm_pkg::CLK_SEL_HI;
    endfunction

    function automatic logic [7:0] ram_answer(input logic [14:0] addr);
        if (!ram_on) return cbm_pkg::NO_ANSWER;
        if (ram_sel_reg <= RAM_SEL_LAST) begin
            if (ram_span(cfg_ram_code) == 0) return cbm_pkg::NO_ANSWER;
            return ram_image[ram_spot(addr)];
        end
        if (clock_selected()) return rtc_latched[ram_sel_reg - cbm_pkg::CLK_SEL_LO];
        return cbm_pkg::NO_ANSWER;
    endfunction

    // advance the mirror by one accepted word and queue any read byte
    task automatic apply_bus_word(input t_bus_word w);
        logic [31:0] days;
        case (w.func)
            cbm_pkg::FN_ROM_RD: begin
                if (cfg_rom_banks == 8'd0) read_bytes_due.push_back(cbm_pkg::NO_ANSWER);
                else read_bytes_due.push_back(rom_image[rom_index(w.addr)]);
            end
            cbm_pkg::FN_CTRL_WR: begin
                if (w.addr < cbm_pkg::CTRL_BANK_LO) begin
                    ram_on = (w.value[3:0] == cbm_pkg::RAM_EN_KEY);
                end else if (w.addr < cbm_pkg::CTRL_SEL_LO) begin
                    rom_bank_reg = w.value[6:0];
                    if (rom_bank_reg == 7'd0) rom_bank_reg = cbm_pkg::BANK_RESET;
                end else if (w.addr < cbm_pkg::CTRL_LATCH_LO) begin
                    ram_sel_reg = w.value;
                end else begin
                    if (last_latch_write == cbm_pkg::LATCH_ARM &&
                        w.value == cbm_pkg::LATCH_FIRE)
                        rtc_latched = rtc_live;
                    last_latch_write = w.value;
                end
            end
            cbm_pkg::FN_RAM_RD: read_bytes_due.push_back(ram_answer(w.addr));
            cbm_pkg::FN_RAM_WR: begin
                if (ram_on) begin
                    if (ram_sel_reg <= RAM_SEL_LAST) begin
                        if (ram_span(cfg_ram_code) != 0) ram_image[ram_spot(w.addr)] = w.value;
                    end else if (clock_selected()) begin
                        rtc_live[ram_sel_reg - cbm_pkg::CLK_SEL_LO] = w.value;
                    end
                end
            end
            cbm_pkg::FN_CLK_LOAD: begin
                days = w.seconds / 86400;
                rtc_live[0] = 8'(w.seconds % 60);
                rtc_live[1] = 8'((w.seconds / 60) % 60);
                rtc_live[2] = 8'((w.seconds / 3600) % 24);
                rtc_live[3] = days[7:0];
                rtc_live[4] = {7'd0, days[8]};
                rtc_latched = rtc_live;
                clock_loads++;
            end
            cbm_pkg::FN_ROM_LOAD: rom_image[w.load_addr] = w.value;
            default: ;
        endcase
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // compare every accepted read byte with the oldest one owed
    always @(posedge i_clk) begin : check_read
        logic [7:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            reads_checked++;
            if (read_bytes_due.size() == 0) begin
                $error("read_data: no read pending, got %h", o_read_data);
                errors++;
            end else begin
                want = read_bytes_due.pop_front();
                if (o_read_data !== want) begin
                    $error("read_data: expected %h, actual %h", want, o_read_data);
                    errors++;
                end
            end
        end
    end

    // receiver stall bursts
    initial begin
        @(posedge i_clk);
        forever begin
            if (!(quiet || calm) && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // present one word, hold it until accepted, then update the mirror
    task automatic send_word(input t_bus_word w);
        if (!(quiet || calm) && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= w.func;
        i_addr      <= w.addr;
        i_value     <= w.value;
        i_seconds   <= w.seconds;
        i_load_addr <= w.load_addr;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        apply_bus_word(w);
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
    endtask

    // unused fields carry random bits
    function automatic t_bus_word blank_word(input logic [2:0] func);
        t_bus_word w;
        w.func      = func;
        w.addr      = 15'($urandom);
        w.value     = 8'($urandom);
        w.seconds   = $urandom;
        w.load_addr = 21'($urandom);
        return w;
    endfunction

    task automatic send_control(input logic [14:0] addr, input logic [7:0] value);
        t_bus_word w;
        w = blank_word(cbm_pkg::FN_CTRL_WR);
        w.addr  = addr;
        w.value = value;
        send_word(w);
    endtask

    task automatic send_ram_write(input logic [14:0] addr, input logic [7:0] value);
        t_bus_word w;
        w = blank_word(cbm_pkg::FN_RAM_WR);
        w.addr  = addr;
        w.value = value;
        send_word(w);
    endtask

    task automatic send_ram_read(input logic [14:0] addr);
        t_bus_word w;
        w = blank_word(cbm_pkg::FN_RAM_RD);
        w.addr = addr;
        send_word(w);
    endtask

    task automatic send_clock_load(input logic [31:0] secs);
        t_bus_word w;
        w = blank_word(cbm_pkg::FN_CLK_LOAD);
        w.seconds = secs;
        send_word(w);
    endtask

    // ROM read; a byte is loaded first if the read would reach an empty entry
    task automatic send_rom_read(input logic [14:0] addr);
        t_bus_word w;
        logic [20:0] idx;
        if (cfg_rom_banks != 8'd0) begin
            idx = rom_index(addr);
            if (!rom_image.exists(idx)) begin
                w = blank_word(cbm_pkg::FN_ROM_LOAD);
                w.load_addr = idx;
                send_word(w);
            end
        end
        w = blank_word(cbm_pkg::FN_ROM_RD);
        w.addr = addr;
        send_word(w);
    endtask

    // wait until the block has nothing left in flight
    task automatic wait_idle();
        release_input();
        while (read_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == cbm_pkg::CFG_ROM_BANKS) cfg_rom_banks = data;
        else cfg_ram_code = data[1:0];
        @(posedge i_clk);
    endtask

    task automatic set_layout(input logic [7:0] banks, input logic [1:0] code);
        wait_idle();
        write_register(cbm_pkg::CFG_ROM_BANKS, banks);
        write_register(cbm_pkg::CFG_RAM_SIZE, {6'd0, code});
        settings_tried++;
    endtask

    // defaults straight out of reset: two banks, no RAM, RAM disabled
    task automatic test_reset_defaults();
        send_rom_read(15'h4000);
        send_ram_read(15'h0000);
        send_control(15'h0000, {4'h5, cbm_pkg::RAM_EN_KEY});
        send_ram_read(15'h1234);
        send_word(blank_word(FN_SPARE6));
        send_word(blank_word(FN_SPARE7));
    endtask

    // fixed bank 0, switched bank, bank 0 turning into 1, no ROM
    task automatic test_rom_banking();
        set_layout(8'd128, RAM_32K);
        send_rom_read(15'h0000);
        send_rom_read(15'h3FFF);
        send_control(cbm_pkg::CTRL_BANK_LO, 8'h00);
        send_rom_read(15'h4000);
        send_control(15'h3FFF, 8'hFF);
        send_rom_read(15'h7FFF);
        set_layout(8'd0, RAM_32K);
        send_rom_read(15'h5555);
    endtask

    // RAM bank wrap and selects that reach nothing
    task automatic test_ram_banking();
        send_control(15'h1FFF, {4'h0, cbm_pkg::RAM_EN_KEY});
        send_control(cbm_pkg::CTRL_SEL_LO, 8'h03);
        send_ram_write(15'h1FFF, 8'hA5);
        send_control(cbm_pkg::CTRL_SEL_LO, 8'h00);
        send_ram_read(15'h7FFF);
        send_control(15'h5FFF, 8'h05);
        send_ram_read(15'h0000);
        send_control(cbm_pkg::CTRL_SEL_LO, 8'hFF);
        send_ram_read(15'h0000);
        send_control(15'h0000, 8'h00);
        send_ram_read(15'h0000);
    endtask

    // live clock writes, the latch pair, clock loads with day overflow
    task automatic test_clock_bytes();
        send_control(15'h0000, {4'h0, cbm_pkg::RAM_EN_KEY});
        send_control(cbm_pkg::CTRL_SEL_LO, cbm_pkg::CLK_SEL_LO);
        send_ram_write(15'h0000, 8'h3C);
        send_ram_read(15'h0000);
        send_control(cbm_pkg::CTRL_LATCH_LO, cbm_pkg::LATCH_ARM);
        send_control(15'h7FFF, cbm_pkg::LATCH_FIRE);
        send_ram_read(15'h0000);
        send_clock_load(32'hFFFF_FFFF);
        send_control(cbm_pkg::CTRL_SEL_LO, cbm_pkg::CLK_SEL_HI);
        send_ram_read(15'h0000);
        send_clock_load(32'd86400 * 600 + 32'd3661);
        send_control(cbm_pkg::CTRL_SEL_LO, 8'h0B);
        send_ram_read(15'h0000);
    endtask

    // control write biased toward useful values per region
    task automatic random_control();
        logic [1:0]  region;
        logic [7:0]  value;
        int          r;
        region = 2'($urandom);
        value  = 8'($urandom);
        r      = $urandom_range(0, 9);
        case (region)
            2'd0: if (r < 7) value = {4'($urandom), cbm_pkg::RAM_EN_KEY};
            2'd1: if (r == 0) value = 8'h00;
            2'd2: begin
                if (r < 5) value = 8'($urandom_range(0, 3));
                else if (r < 9) value = 8'($urandom_range(cbm_pkg::CLK_SEL_LO,
                                                          cbm_pkg::CLK_SEL_HI));
            end
            default: if (r < 7) value = (r < 4) ? cbm_pkg::LATCH_ARM : cbm_pkg::LATCH_FIRE;
        endcase
        send_control({region, 13'($urandom)}, value);
    endtask

    function automatic logic [14:0] pick_addr(ref logic [14:0] pool [$]);
        if (pool.size() != 0 && $urandom_range(0, 1) == 0)
            return pool[$urandom_range(0, pool.size() - 1)];
        return 15'($urandom);
    endfunction

    function automatic void remember(ref logic [14:0] pool [$], input logic [14:0] addr);
        pool.push_back(addr);
        if (pool.size() > 16) void'(pool.pop_front());
    endfunction

    // random mix of all operations over several bank and RAM layouts
    task automatic test_random_mix();
        logic [7:0]  banks [RANDOM_PHASES] = '{8'd128, 8'd0, 8'd1, 8'd3, 8'd2,
                                               8'd100, 8'd64, 8'd127, 8'd16};
        logic [1:0]  codes [RANDOM_PHASES] = '{RAM_32K, cbm_pkg::RAM_NONE, cbm_pkg::RAM_2K,
                                               cbm_pkg::RAM_8K, RAM_32K, cbm_pkg::RAM_2K,
                                               cbm_pkg::RAM_8K, RAM_32K, cbm_pkg::RAM_8K};
        logic [14:0] addr;
        t_bus_word   w;
        int          r;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_layout(banks[p], codes[p]);
            quiet = (p == RANDOM_PHASES - 1);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 18) begin
                    addr = pick_addr(recent_rom_addr);
                    remember(recent_rom_addr, addr);
                    send_rom_read(addr);
                end else if (r < 40) begin
                    random_control();
                end else if (r < 62) begin
                    send_ram_read(pick_addr(recent_ram_addr));
                end else if (r < 84) begin
                    addr = pick_addr(recent_ram_addr);
                    remember(recent_ram_addr, addr);
                    send_ram_write(addr, 8'($urandom));
                end else if (r < 87) begin
                    send_clock_load(($urandom_range(0, 1) == 0) ? $urandom
                                                                : $urandom_range(0, 86400 * 600));
                end else if (r < 96) begin
                    send_word(blank_word(cbm_pkg::FN_ROM_LOAD));
                end else begin
                    w = blank_word(($urandom_range(0, 1) == 0) ? FN_SPARE6 : FN_SPARE7);
                    send_word(w);
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_rom_banking();
        test_ram_banking();
        test_clock_bytes();
        test_random_mix();
        wait_idle();
        $display("tb: %0d words accepted, %0d read bytes compared", words_sent, reads_checked);
        $display("tb: %0d bank/RAM layouts, %0d clock loads", settings_tried, clock_loads);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
